// ----- rtl/dtq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// shared types and constants of the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int TIME_W   = 48;
  localparam int DELAY_W  = 32;
  localparam int OWNER_W  = 16;
  localparam int SIGNAL_W = 6;
  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;
  localparam int EMIT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [TIME_W-1:0]   deadline;
    logic [OWNER_W-1:0]  owner;
    logic [SIGNAL_W-1:0] signal_num;
    logic [ID_W-1:0]     timer_id;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/dtq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_cell
// one slot of the sorted timer chain
// ----------------------------------------------------------------------------
module dtq_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dtq_pkg::cell_ctrl_t ctrl_i,
  input  wire dtq_pkg::entry_t    new_i,
  input  wire dtq_pkg::entry_t    left_i,
  input  wire dtq_pkg::entry_t    right_i,
  input  wire logic               left_after_i,
  output dtq_pkg::entry_t         entry_o,
  output logic                    after_o
);

  logic                         valid_q, valid_d;
  logic [dtq_pkg::TIME_W-1:0]   deadline_q;
  logic [dtq_pkg::OWNER_W-1:0]  owner_q;
  logic [dtq_pkg::SIGNAL_W-1:0] signal_q;
  logic [dtq_pkg::ID_W-1:0]     id_q;
  dtq_pkg::entry_t              cur, nxt;

  assign cur = '{valid: valid_q, deadline: deadline_q, owner: owner_q,
                 signal_num: signal_q, timer_id: id_q};

  // slot is at or past the insertion point of the new deadline
  assign after_o = !valid_q || (deadline_q > new_i.deadline);

  always_comb begin
    nxt = cur;
    if (ctrl_i.pop) begin
      nxt = right_i;
    end else if (ctrl_i.insert && after_o) begin
      nxt = left_after_i ? left_i : new_i;
    end
  end

  assign valid_d = nxt.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= nxt.deadline;
    owner_q    <= nxt.owner;
    signal_q   <= nxt.signal_num;
    id_q       <= nxt.timer_id;
  end

  assign entry_o = cur;

endmodule
`default_nettype wire

// ----- rtl/deadline_timer_queue_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// one-shot timer queue kept sorted by deadline in a chain of cells
// ----------------------------------------------------------------------------
// An add beat stores a timer with deadline = now + delay (saturating at the
// top of the 48-bit clock) and returns one accept or reject beat; a tick beat
// advances the millisecond clock and returns one expiry beat per timer whose
// deadline is strictly below the new clock, in deadline order, with last set
// on the final one (no beat at all when nothing is due). Timers live in a row
// of cells ordered by deadline, equal deadlines in arrival order; an insert
// shifts the cells past the insertion point one slot right at once, an
// expiry shifts the whole row one slot left. An add latches the deadline
// from the adder, then compares and shifts in the cells; a tick advances
// the clock, then emits the head cell once per cycle while it is due and
// the output does not stall. A stalled output holds the add or expiry in
// progress. One item is worked on at a time; a finished beat sits in the
// output register and the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [dtq_pkg::DELAY_W-1:0]  delay_ms_i,
  input  wire logic [dtq_pkg::OWNER_W-1:0]  owner_i,
  input  wire logic [dtq_pkg::SIGNAL_W-1:0] signal_num_i,
  input  wire logic [dtq_pkg::ID_W-1:0]     timer_id_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [dtq_pkg::KIND_W-1:0]        kind_o,
  output logic [dtq_pkg::OWNER_W-1:0]       owner_out_o,
  output logic [dtq_pkg::SIGNAL_W-1:0]      signal_out_o,
  output logic [dtq_pkg::ID_W-1:0]          id_out_o,
  output logic                              last_o
);

  localparam int N = dtq_pkg::QUEUE_DEPTH;

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ADD   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  // millisecond clock
  logic [dtq_pkg::TIME_W-1:0] now_q, now_d;

  // latched add beat, deadline already computed
  logic [dtq_pkg::TIME_W-1:0]   dl_q;
  logic [dtq_pkg::OWNER_W-1:0]  add_owner_q;
  logic [dtq_pkg::SIGNAL_W-1:0] add_signal_q;
  logic [dtq_pkg::ID_W-1:0]     add_id_q;

  // expiries emitted during the current tick
  logic [dtq_pkg::EMIT_W-1:0] emit_q, emit_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [dtq_pkg::KIND_W-1:0]   kind_q, kind_d;
  logic [dtq_pkg::OWNER_W-1:0]  oown_q, oown_d;
  logic [dtq_pkg::SIGNAL_W-1:0] osig_q, osig_d;
  logic [dtq_pkg::ID_W-1:0]     oid_q, oid_d;
  logic                         olast_q, olast_d;

  logic in_acc;
  logic out_free;
  logic [dtq_pkg::TIME_W:0]   dl_sum;
  logic [dtq_pkg::TIME_W-1:0] dl_sat;

  dtq_pkg::cell_ctrl_t ctrl;
  dtq_pkg::entry_t     ins_entry;
  dtq_pkg::entry_t     cell_ent   [N];
  dtq_pkg::entry_t     left_ent   [N];
  dtq_pkg::entry_t     right_ent  [N];
  logic                after_f    [N];
  logic                left_after [N];

  logic full;
  logic due0, due1;
  logic room_more;

  // one item at a time; the output register frees the input side
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // saturating deadline adder
  assign dl_sum = {1'b0, now_q} + {{(dtq_pkg::TIME_W + 1 - dtq_pkg::DELAY_W){1'b0}}, delay_ms_i};
  assign dl_sat = dl_sum[dtq_pkg::TIME_W] ? {dtq_pkg::TIME_W{1'b1}}
                                          : dl_sum[dtq_pkg::TIME_W-1:0];

  assign ins_entry = '{valid: 1'b1, deadline: dl_q, owner: add_owner_q,
                       signal_num: add_signal_q, timer_id: add_id_q};

  // cell chain: left neighbor feeds inserts, right neighbor feeds pops
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_ent[i]   = ins_entry;
      assign left_after[i] = 1'b0;
    end else begin : g_body
      assign left_ent[i]   = cell_ent[i-1];
      assign left_after[i] = after_f[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_ent[i] = '0;
    end else begin : g_mid
      assign right_ent[i] = cell_ent[i+1];
    end

    dtq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (ins_entry),
      .left_i       (left_ent[i]),
      .right_i      (right_ent[i]),
      .left_after_i (left_after[i]),
      .entry_o      (cell_ent[i]),
      .after_o      (after_f[i])
    );
  end

  // queue full when the tail cell holds a timer
  assign full = cell_ent[N-1].valid;

  // head and next-to-head due against the already advanced clock
  assign due0      = cell_ent[0].valid && (cell_ent[0].deadline < now_q);
  assign due1      = cell_ent[1].valid && (cell_ent[1].deadline < now_q);
  assign room_more = (emit_q + 1'b1) < dtq_pkg::EMIT_W'(dtq_pkg::MAX_RESULTS);

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    emit_d      = emit_q;
    ctrl        = '{insert: 1'b0, pop: 1'b0};
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    oown_d      = oown_q;
    osig_d      = osig_q;
    oid_d       = oid_q;
    olast_d     = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == dtq_pkg::OP_TICK) begin
            now_d   = now_q + 1'b1;
            emit_d  = '0;
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = full ? dtq_pkg::KIND_REJECT : dtq_pkg::KIND_ACCEPT;
          oown_d      = add_owner_q;
          osig_d      = add_signal_q;
          oid_d       = add_id_q;
          olast_d     = 1'b1;
          ctrl.insert = !full;
          state_d     = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!due0) begin
          // nothing (more) due on this tick
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = dtq_pkg::KIND_EXPIRY;
          oown_d      = cell_ent[0].owner;
          osig_d      = cell_ent[0].signal_num;
          oid_d       = cell_ent[0].timer_id;
          olast_d     = !(due1 && room_more);
          ctrl.pop    = 1'b1;
          emit_d      = emit_q + 1'b1;
          if (!(due1 && room_more)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dl_q         <= dl_sat;
      add_owner_q  <= owner_i;
      add_signal_q <= signal_num_i;
      add_id_q     <= timer_id_i;
    end
    kind_q  <= kind_d;
    oown_q  <= oown_d;
    osig_q  <= osig_d;
    oid_q   <= oid_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign owner_out_o  = oown_q;
  assign signal_out_o = osig_q;
  assign id_out_o     = oid_q;
  assign last_o       = olast_q;

endmodule
`default_nettype wire

// ----- sim/tb_deadline_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue_unit
// self-checking bench for the sorted one-shot timer queue
// ----------------------------------------------------------------------------
// Add and tick beats go into the queue through a valid/stall channel. As each
// beat is accepted, a behavioral timer list inside the bench works out the
// accept, reject or expiry beats that it must cause. Every result beat taken
// from the block is checked field by field against the oldest of those.
// Directed tests cover a full queue with equal deadlines draining in one
// tick, and the extremes of every field. A long receiver hold-off backs the
// block up into its input. Random traffic then runs with idle bursts on both
// sides, and finally with none.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dtq_pkg::*;

  localparam int LONG_HOLD_CYCLES = 200;
  // upper bound on the whole run in nanoseconds
  localparam longint TIMEOUT_NS   = 64'd20_000_000;
  // a tick drains at most 16 expiries at one per cycle while the output does not stall
  localparam int SETTLE_CYCLES    = 40;

  // one stored timer, kept in deadline order
  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [OWNER_W-1:0]  owner;
    logic [SIGNAL_W-1:0] signal_num;
    logic [ID_W-1:0]     timer_id;
  } timer_rec_t;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OWNER_W-1:0]  owner;
    logic [SIGNAL_W-1:0] signal_num;
    logic [ID_W-1:0]     timer_id;
    logic                last;
  } result_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                opcode_i;
  logic [DELAY_W-1:0]  delay_ms_i;
  logic [OWNER_W-1:0]  owner_i;
  logic [SIGNAL_W-1:0] signal_num_i;
  logic [ID_W-1:0]     timer_id_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [KIND_W-1:0]   kind_o;
  logic [OWNER_W-1:0]  owner_out_o;
  logic [SIGNAL_W-1:0] signal_out_o;
  logic [ID_W-1:0]     id_out_o;
  logic                last_o;

  // behavioral copy of the queue state
  timer_rec_t        model_timers[$];
  logic [TIME_W-1:0] model_now_ms;
  // result beats still owed by the block, oldest first
  result_beat_t      awaited_beats[$];

  // pacing controls
  bit src_idle_en;
  bit sink_idle_en;
  int hold_off_left;

  // bookkeeping for the summary
  int failures;
  int adds_sent;
  int ticks_sent;
  int accepts_seen;
  int rejects_seen;
  int expiries_seen;

  deadline_timer_queue_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .delay_ms_i   (delay_ms_i),
    .owner_i      (owner_i),
    .signal_num_i (signal_num_i),
    .timer_id_i   (timer_id_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .owner_out_o  (owner_out_o),
    .signal_out_o (signal_out_o),
    .id_out_o     (id_out_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // timer list prediction
  // --------------------------------------------------------------------------
  function automatic result_beat_t make_beat(input logic [KIND_W-1:0] kind,
                                             input logic [OWNER_W-1:0] owner,
                                             input logic [SIGNAL_W-1:0] sig,
                                             input logic [ID_W-1:0] id,
                                             input logic last);
    result_beat_t b;
    b.kind       = kind;
    b.owner      = owner;
    b.signal_num = sig;
    b.timer_id   = id;
    b.last       = last;
    return b;
  endfunction

  function automatic string beat_str(input result_beat_t b);
    return $sformatf("kind=%0d owner=%h sig=%0d id=%h last=%0b",
                     b.kind, b.owner, b.signal_num, b.timer_id, b.last);
  endfunction

  // apply one accepted beat to the timer list and queue up what it causes
  function automatic void timer_list_step(input logic op,
                                          input logic [DELAY_W-1:0] delay,
                                          input logic [OWNER_W-1:0] owner,
                                          input logic [SIGNAL_W-1:0] sig,
                                          input logic [ID_W-1:0] id);
    logic [TIME_W:0] sum;
    timer_rec_t      rec;
    int              pos;
    int              n_due;
    int              k;
    if (op == OP_ADD) begin
      if (model_timers.size() >= QUEUE_DEPTH) begin
        // full queue: rejected, list untouched
        awaited_beats.push_back(make_beat(KIND_REJECT, owner, sig, id, 1'b1));
      end else begin
        // deadline saturates at the top of the 48-bit clock
        sum = {1'b0, model_now_ms} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
        rec.deadline   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        rec.owner      = owner;
        rec.signal_num = sig;
        rec.timer_id   = id;
        // behind every entry with the same or an earlier deadline
        pos = model_timers.size();
        while (pos > 0 && model_timers[pos-1].deadline > rec.deadline) begin
          pos--;
        end
        model_timers.insert(pos, rec);
        awaited_beats.push_back(make_beat(KIND_ACCEPT, owner, sig, id, 1'b1));
      end
    end else begin
      model_now_ms = model_now_ms + 1'b1;
      n_due = 0;
      while (n_due < model_timers.size() && n_due < MAX_RESULTS &&
             model_timers[n_due].deadline < model_now_ms) begin
        n_due++;
      end
      for (k = 0; k < n_due; k++) begin
        awaited_beats.push_back(make_beat(KIND_EXPIRY, model_timers[k].owner,
                                          model_timers[k].signal_num,
                                          model_timers[k].timer_id,
                                          k == n_due - 1));
      end
      repeat (n_due) void'(model_timers.pop_front());
    end
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // offer one beat, hold it until taken, then predict; returns at the
  // accepting edge, so the next drive happens at the following falling edge
  task automatic send_beat(input logic op, input logic [DELAY_W-1:0] delay,
                           input logic [OWNER_W-1:0] owner,
                           input logic [SIGNAL_W-1:0] sig,
                           input logic [ID_W-1:0] id);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      // idle burst with valid low
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    delay_ms_i   <= delay;
    owner_i      <= owner;
    signal_num_i <= sig;
    timer_id_i   <= id;
    do @(posedge clk_i); while (in_stall_o);
    timer_list_step(op, delay, owner, sig, id);
    if (op == OP_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  // payload fields come in as 32-bit values and are cut to their widths here
  task automatic send_add(input logic [DELAY_W-1:0] delay,
                          input int unsigned owner,
                          input int unsigned sig,
                          input int unsigned id);
    send_beat(OP_ADD, delay, OWNER_W'(owner), SIGNAL_W'(sig), ID_W'(id));
  endtask

  // the add-only fields are don't-care on a tick, so they get noise
  task automatic send_tick();
    send_beat(OP_TICK, $urandom, OWNER_W'($urandom), SIGNAL_W'($urandom),
              ID_W'($urandom));
  endtask

  // drop valid and wait until every owed result beat has come back
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------
  // stall pacing: a requested long hold-off first, then random bursts
  initial begin : sink_pacing
    int burst;
    burst = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(1, 18) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // every result beat taken is matched against the oldest owed one
  always @(posedge clk_i) begin : result_check
    result_beat_t got;
    result_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = make_beat(kind_o, owner_out_o, signal_out_o, id_out_o, last_o);
      case (got.kind)
        KIND_ACCEPT: accepts_seen++;
        KIND_REJECT: rejects_seen++;
        default:     expiries_seen++;
      endcase
      if (awaited_beats.size() == 0) begin
        if (failures < 10) $display("ERROR: unexpected result beat %s", beat_str(got));
        failures++;
      end else begin
        want = awaited_beats.pop_front();
        if (got.kind !== want.kind || got.owner !== want.owner ||
            got.signal_num !== want.signal_num || got.timer_id !== want.timer_id ||
            got.last !== want.last) begin
          if (failures < 10) begin
            $display("ERROR: result beat mismatch at %0t", $time);
            $display("  expected %s", beat_str(want));
            $display("  actual   %s", beat_str(got));
          end
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // sixteen adds with one deadline fill the queue, the next one is turned
  // away; the first tick finds nothing due, the second drains all sixteen
  // in arrival order
  task automatic test_fill_and_burst_expiry();
    repeat (QUEUE_DEPTH) send_add(1, $urandom, $urandom, $urandom);
    send_add(1, $urandom, $urandom, $urandom);
    send_tick();
    send_tick();
  endtask

  // all-zero and all-one payloads, plus the longest delay, which parks a
  // timer that never comes due in this run
  task automatic test_field_extremes();
    send_add(0, '0, '0, '0);
    send_add(0, '1, '1, '1);
    send_add('1, 'h5a5a, 'h15, 'ha5a5);
    send_tick();
  endtask

  // receiver holds off for a long stretch while adds and a tick keep coming,
  // so the output register fills and the input backs up
  task automatic test_output_backpressure();
    hold_off_left = LONG_HOLD_CYCLES;
    repeat (5) send_add(0, $urandom, $urandom, $urandom);
    send_tick();
    send_add($urandom_range(0, 3), $urandom, $urandom, $urandom);
  endtask

  // mostly short delays so timers keep expiring; now and then a run of adds
  // pushes the queue toward full, and a rare full-range delay parks a timer
  task automatic run_random_traffic(input int n_items);
    int sent;
    int pick;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        run_len = $urandom_range(4, 12);
        repeat (run_len) send_add($urandom_range(0, 10), $urandom, $urandom, $urandom);
        sent += run_len;
      end else if (pick < 50) begin
        send_tick();
        sent++;
      end else begin
        send_add(($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, 6),
                 $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_ADD;
    delay_ms_i    = '0;
    owner_i       = '0;
    signal_num_i  = '0;
    timer_id_i    = '0;
    model_now_ms  = '0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    hold_off_left = 0;
    failures      = 0;
    adds_sent     = 0;
    ticks_sent    = 0;
    accepts_seen  = 0;
    rejects_seen  = 0;
    expiries_seen = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_burst_expiry();
    wait_for_drain();
    test_field_extremes();
    wait_for_drain();
    test_output_backpressure();
    wait_for_drain();
    run_random_traffic(60);
    wait_for_drain();
    // closing stretch at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_traffic(20);
    wait_for_drain();
    // let any tick that had nothing due finish, watching for stray beats
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d add beats and %0d tick beats, ending at %0d ms.",
             adds_sent, ticks_sent, model_now_ms);
    $display("Checked %0d accepts, %0d rejects, %0d expiries; %0d failures.",
             accepts_seen, rejects_seen, expiries_seen, failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
